[rtl/assert_macros.svh]
// shared assertion macros for the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, ignored while rst is high
`define RCE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rce checker: same-cycle property failed");

// next-cycle implication, sampled on clk, ignored while rst is high
`define RCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rce checker: next-cycle property failed");

`endif

[rtl/rce_pkg.sv]
package rce_pkg;

  localparam int INT_BITS        = 31;
  localparam int FRAC_BITS       = 32;
  localparam int MAX_FRAC_DIGITS = 32;
  localparam int RESULT_LIMIT    = 63;

  localparam int DIGIT_W  = 4;
  localparam int RADIX_W  = 5;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

  localparam logic [RADIX_W-1:0] RADIX_RESET     = 5'd10;
  localparam logic [FRAC_BITS-1:0] THRESHOLD_RESET = 32'd429;

  // divide-by-radix unit: quotient bits per cycle and steps per digit
  localparam int DIV_CHUNK  = 8;
  localparam int DIV_STEPS  = (INT_BITS + DIV_CHUNK - 1) / DIV_CHUNK;
  localparam int DIV_W      = DIV_STEPS * DIV_CHUNK;
  localparam int DIV_STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // integer digit stack: base 2 gives one digit per bit
  localparam int STACK_DEPTH = INT_BITS;
  localparam int STACK_IDX_W = $clog2(STACK_DEPTH);
  localparam int ND_W        = $clog2(STACK_DEPTH + 1);
  localparam int CNT_W       = $clog2(RESULT_LIMIT + 1);
  localparam int FCNT_W      = $clog2(MAX_FRAC_DIGITS + 1);

  typedef struct packed {
    logic [INT_BITS-1:0]  int_part;
    logic [FRAC_BITS-1:0] frac_part;
  } rce_in_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               in_fraction;
    logic               first_fraction;
    logic               last_digit;
  } rce_out_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic pop;
    logic frac_step;
  } rce_cmd_t;

  typedef struct packed {
    logic v_zero;
    logic nd_zero;
    logic nd_one;
    logic frac_go;
    logic frac_last;
  } rce_status_t;

  function automatic logic [RADIX_W-1:0] radix_clamp(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_W'(2)) begin
      res = RADIX_W'(2);
    end else if (r > RADIX_W'(16)) begin
      res = RADIX_W'(16);
    end else begin
      res = r;
    end
    return res;
  endfunction

endpackage

[rtl/rce_ctrl.sv]
module rce_ctrl
  import rce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  rce_status_t st,
  output rce_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_POP  = 4'b0100,
    S_FRAC = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        // the value only changes at a digit boundary, so zero means done
        if (st.v_zero) begin
          state_next = st.nd_zero ? S_FRAC : S_POP;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        if (st.nd_one) begin
          state_next = S_FRAC;
        end
      end
      S_FRAC: begin
        if (st.frac_go) begin
          cmd.frac_step = 1'b1;
          if (st.frac_last) begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

[rtl/rce_datapath.sv]
module rce_datapath
  import rce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  rce_cmd_t             cmd,
  input  rce_in_t              operand,
  input  logic [RADIX_W-1:0]   radix,
  input  logic [FRAC_BITS-1:0] frac_threshold,
  output rce_status_t          st,
  output rce_out_t             result,
  output logic                 result_valid
);

  logic [INT_BITS-1:0]   v;
  logic [FRAC_BITS-1:0]  f;
  logic [RADIX_W-1:0]    r;
  logic [DIV_W-1:0]      sh;
  logic [DIGIT_W-1:0]    rem;
  logic [DIV_STEP_W-1:0] dstep;
  logic [ND_W-1:0]       nd;
  logic [CNT_W-1:0]      cnt;
  logic [FCNT_W-1:0]     fcnt;
  logic [DIGIT_W-1:0]    stack [STACK_DEPTH];

  logic [DIV_W-1:0]            dn;
  logic [RADIX_W-1:0]          rem_w;
  logic [RADIX_W-1:0]          trial;
  logic                        div_last;
  logic [FRAC_BITS+RADIX_W-1:0] prod;
  logic [FRAC_BITS-1:0]        f_new;
  logic [DIGIT_W-1:0]          f_digit;
  logic [STACK_IDX_W-1:0]      push_idx;
  logic [STACK_IDX_W-1:0]      pop_idx;
  logic [ND_W-1:0]             nd_dec;
  logic                        f_above;
  logic                        pop_last;

  // eight restoring steps of divide-by-radix, remainder stays below 16
  always_comb begin
    dn    = (dstep == '0) ? DIV_W'(v) : sh;
    rem_w = (dstep == '0) ? '0 : RADIX_W'(rem);
    trial = '0;
    for (int k = 0; k < DIV_CHUNK; k++) begin
      trial = {rem_w[DIGIT_W-1:0], dn[DIV_W-1]};
      dn    = {dn[DIV_W-2:0], 1'b0};
      if (trial >= r) begin
        rem_w = trial - r;
        dn[0] = 1'b1;
      end else begin
        rem_w = trial;
      end
    end
  end

  assign div_last = (dstep == DIV_STEP_W'(DIV_STEPS - 1));
  assign push_idx = nd[STACK_IDX_W-1:0];
  assign nd_dec   = nd - ND_W'(1);
  assign pop_idx  = nd_dec[STACK_IDX_W-1:0];

  assign prod    = FRAC_BITS'(f) * r;
  assign f_new   = prod[FRAC_BITS-1:0];
  assign f_digit = prod[FRAC_BITS+DIGIT_W-1:FRAC_BITS];
  assign f_above = (f > frac_threshold);

  // fraction digits follow while above threshold and under both caps
  assign st.frac_go = f_above && (fcnt < FCNT_W'(MAX_FRAC_DIGITS))
                      && (cnt < CNT_W'(RESULT_LIMIT));
  assign st.frac_last = (f_new <= frac_threshold)
                        || (fcnt == FCNT_W'(MAX_FRAC_DIGITS - 1))
                        || (cnt == CNT_W'(RESULT_LIMIT - 1));
  assign pop_last = (nd == ND_W'(1))
                    && !(f_above && (cnt < CNT_W'(RESULT_LIMIT - 1)));
  assign st.v_zero  = (v == '0);
  assign st.nd_zero = (nd == '0);
  assign st.nd_one  = (nd == ND_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.div_step && div_last) begin
      stack[push_idx] <= rem_w[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstep        <= '0;
      nd           <= '0;
      cnt          <= '0;
      fcnt         <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cmd.load) begin
        dstep <= '0;
        nd    <= '0;
        cnt   <= '0;
        fcnt  <= '0;
      end
      if (cmd.div_step) begin
        if (div_last) begin
          dstep <= '0;
          nd    <= nd + ND_W'(1);
        end else begin
          dstep <= dstep + DIV_STEP_W'(1);
        end
      end
      if (cmd.pop) begin
        nd           <= nd_dec;
        cnt          <= cnt + CNT_W'(1);
        result_valid <= 1'b1;
      end
      if (cmd.frac_step) begin
        fcnt         <= fcnt + FCNT_W'(1);
        cnt          <= cnt + CNT_W'(1);
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v <= operand.int_part;
      f <= operand.frac_part;
      r <= radix_clamp(radix);
    end
    if (cmd.div_step) begin
      sh  <= dn;
      rem <= rem_w[DIGIT_W-1:0];
      if (div_last) begin
        v <= dn[INT_BITS-1:0];
      end
    end
    if (cmd.pop) begin
      result.digit          <= stack[pop_idx];
      result.in_fraction    <= 1'b0;
      result.first_fraction <= 1'b0;
      result.last_digit     <= pop_last;
    end
    if (cmd.frac_step) begin
      f                     <= f_new;
      result.digit          <= f_digit;
      result.in_fraction    <= 1'b1;
      result.first_fraction <= (fcnt == '0);
      result.last_digit     <= st.frac_last;
    end
  end

endmodule

[rtl/radix_conversion_digit_emitter_top.sv]
// radix conversion digit emitter: takes a non-negative fixed-point number (unsigned
// integer part plus a binary fraction scaled by 2^32) on start while busy is low and
// writes it out in base R, one digit per result_valid strobe. integer digits come out
// most significant first, then fraction digits while the remaining fraction is above
// frac_threshold, at most 32 of them. a result is shown for exactly one cycle and the
// receiver cannot stall, so it must take every strobe. an input of zero gives no
// results. radix below 2 acts as 2, above 16 as 16. a transaction loads the operand,
// divides out each integer digit in the shared divide-by-radix unit (eight quotient
// bits a cycle over a 32-bit dividend) and pushes it onto the digit stack, pops and
// emits the integer digits from the stack, then each fraction digit from a 32x5
// multiply. registers must be written only while busy is low; the block itself does
// not enforce it.
module radix_conversion_digit_emitter_top
  import rce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  rce_in_t              operand,
  output rce_out_t             result,
  output logic                 result_valid,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // configuration registers
  logic [RADIX_W-1:0]   radix;
  logic [FRAC_BITS-1:0] frac_threshold;

  // command and status between controller and datapath
  rce_cmd_t    cmd;
  rce_status_t st;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix          <= RADIX_RESET;
      frac_threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIX:     radix          <= cfg_data[RADIX_W-1:0];
        CFG_THRESHOLD: frac_threshold <= cfg_data[FRAC_BITS-1:0];
        default: begin
          // unused index, write is dropped
        end
      endcase
    end
  end

  // sequencing: load, divide digits onto the stack, pop them, then fraction digits
  rce_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy)
  );

  // arithmetic, digit stack, counters and the registered result transaction
  rce_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .operand        (operand),
    .radix          (radix),
    .frac_threshold (frac_threshold),
    .st             (st),
    .result         (result),
    .result_valid   (result_valid)
  );

endmodule

[rtl/rce_checker.sv]
`include "assert_macros.svh"

module rce_checker
  import rce_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input rce_out_t result,
  input logic     result_valid
);

  // an accepted transaction keeps the block busy in the next cycle
  `RCE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // nothing follows straight after the final digit
  `RCE_ASSERT_NEXT(a_last_gap, result_valid && result.last_digit, !result_valid)

  // a result seen after the block went idle must close the transaction
  `RCE_ASSERT_SAME(a_idle_last, result_valid && !busy, result.last_digit)

  // the radix point mark only sits on a fraction digit
  `RCE_ASSERT_SAME(a_first_frac, result_valid && result.first_fraction, result.in_fraction)

endmodule

bind radix_conversion_digit_emitter_top rce_checker u_rce_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result       (result),
  .result_valid (result_valid)
);
